// File: src/i2cms_pkg.sv
// Shared constants, codes, types and helpers of the I2C master transfer sequencer.
`default_nettype none
package i2cms_pkg;

	localparam int MAX_OPS = 8;
	localparam int DATA_ADDR_W = 8;
	localparam int DATA_DEPTH = 1 << DATA_ADDR_W;
	localparam int OP_IW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
	localparam int CNT_W = $clog2(MAX_OPS + 1);

	localparam logic [1:0] ACT_LOAD_DESC = 2'd0;
	localparam logic [1:0] ACT_LOAD_BYTE = 2'd1;
	localparam logic [1:0] ACT_START_JOB = 2'd2;
	localparam logic [1:0] ACT_EVENT     = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BUSY    = 2'd1;
	localparam logic [1:0] ST_DEV_ERR = 2'd2;
	localparam logic [1:0] ST_BUS_ERR = 2'd3;

	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_SEND  = 3'd1;
	localparam logic [2:0] CMD_START = 3'd2;
	localparam logic [2:0] CMD_STOP  = 3'd3;
	localparam logic [2:0] CMD_NACK  = 3'd4;

	localparam logic [3:0] EV_START_DONE   = 4'd0;
	localparam logic [3:0] EV_RSTART_DONE  = 4'd1;
	localparam logic [3:0] EV_WR_ADDR_ACK  = 4'd2;
	localparam logic [3:0] EV_WR_DATA_ACK  = 4'd3;
	localparam logic [3:0] EV_RD_ADDR_ACK  = 4'd4;
	localparam logic [3:0] EV_RD_DATA_ACK  = 4'd5;
	localparam logic [3:0] EV_RD_DATA_NACK = 4'd6;
	localparam logic [3:0] EV_WR_ADDR_NACK = 4'd7;
	localparam logic [3:0] EV_WR_DATA_NACK = 4'd8;
	localparam logic [3:0] EV_RD_ADDR_NACK = 4'd9;
	localparam logic [3:0] EV_OTHER        = 4'd13;

	typedef struct packed {
		logic [1:0] action;
		logic [2:0] op_slot;
		logic [7:0] op_address_byte;
		logic [7:0] op_length;
		logic [7:0] op_offset;
		logic [7:0] byte_index;
		logic [7:0] byte_value;
		logic [3:0] op_count;
		logic [3:0] event_code;
		logic [7:0] rx_data;
		logic       stop_active;
	} item_t;

	typedef struct packed {
		logic [7:0] address_byte;
		logic [7:0] length;
		logic [7:0] offset;
	} desc_t;

	typedef struct packed {
		logic [CNT_W-1:0] current_op;
		logic [CNT_W-1:0] job_op_count;
		logic [7:0]       byte_progress;
		logic [1:0]       driver_status;
	} seq_state_t;

	typedef struct packed {
		logic                   we;
		logic [DATA_ADDR_W-1:0] waddr;
		logic [7:0]             wdata;
		logic                   re;
		logic [DATA_ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] command;
		logic [7:0] tx_byte;
		logic       tx_from_buf;
		logic       rx_store_valid;
		logic [7:0] rx_store_index;
	} result_t;

	function automatic logic [DATA_ADDR_W-1:0] to_addr(input logic [8:0] v);
		logic [DATA_ADDR_W+8:0] w;
		w = {{DATA_ADDR_W{1'b0}}, v};
		return w[DATA_ADDR_W-1:0];
	endfunction

	function automatic logic [7:0] addr_low_byte(input logic [DATA_ADDR_W-1:0] a);
		logic [DATA_ADDR_W+7:0] w;
		w = {8'd0, a};
		return w[7:0];
	endfunction

endpackage
`default_nettype wire

// File: src/i2cms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module i2cms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/i2cms_desc_table.sv
// Operation descriptor table: address byte, length and offset per slot.
`default_nettype none
module i2cms_desc_table
	import i2cms_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [OP_IW-1:0] waddr,
	input  wire desc_t            wdata,
	input  wire logic [OP_IW-1:0] raddr,
	output      desc_t            rdata
);

	desc_t table_q [MAX_OPS];

	always_ff @(posedge clk) begin
		if (we) begin
			table_q[waddr] <= wdata;
		end
	end

	assign rdata = table_q[raddr];

endmodule
`default_nettype wire

// File: src/i2cms_step.sv
// Next-state and command decision for one item of the sequencer.
`default_nettype none
module i2cms_step
	import i2cms_pkg::*;
(
	input  wire item_t      item,
	input  wire seq_state_t cur,
	input  wire desc_t      desc,
	output      seq_state_t nxt,
	output      mem_req_t   mem,
	output      result_t    res
);

	logic [4:0]             cnt5;
	logic [CNT_W-1:0]       op_inc;
	logic [7:0]             len;
	logic [7:0]             prog;
	logic [7:0]             prog_inc;
	logic [DATA_ADDR_W-1:0] pos;
	logic                   do_next;
	logic                   wr_cond;

	always_comb begin
		cnt5     = {1'b0, item.op_count};
		op_inc   = cur.current_op + CNT_W'(1);
		len      = desc.length;
		prog     = cur.byte_progress;
		prog_inc = prog + 8'd1;
		pos      = to_addr({1'b0, desc.offset} + {1'b0, prog});
		wr_cond  = (item.event_code == EV_WR_ADDR_ACK) ? (len != 8'd0) : (prog != len);
		do_next  = 1'b0;

		nxt = cur;
		mem = '0;
		res = '0;
		res.command = CMD_NONE;

		unique case (item.action)
			ACT_LOAD_DESC: begin
			end
			ACT_LOAD_BYTE: begin
				mem.we    = 1'b1;
				mem.waddr = to_addr({1'b0, item.byte_index});
				mem.wdata = item.byte_value;
			end
			ACT_START_JOB: begin
				if (cnt5 == 5'd0) begin
					cnt5 = 5'd1;
				end
				if (cnt5 > 5'(MAX_OPS)) begin
					cnt5 = 5'(MAX_OPS);
				end
				nxt.job_op_count  = cnt5[CNT_W-1:0];
				nxt.current_op    = '0;
				nxt.byte_progress = 8'd0;
				nxt.driver_status = ST_BUSY;
				res.command       = CMD_START;
			end
			ACT_EVENT: begin
				if (cur.current_op >= cur.job_op_count) begin
					nxt.driver_status = ST_BUS_ERR;
				end else begin
					unique case (item.event_code)
						EV_START_DONE, EV_RSTART_DONE: begin
							res.tx_byte       = desc.address_byte;
							res.command       = CMD_SEND;
							nxt.driver_status = ST_BUSY;
						end
						EV_WR_ADDR_ACK, EV_WR_DATA_ACK: begin
							if (wr_cond) begin
								mem.re            = 1'b1;
								mem.raddr         = pos;
								res.tx_from_buf   = 1'b1;
								nxt.byte_progress = prog_inc;
								res.command       = CMD_SEND;
								nxt.driver_status = ST_BUSY;
							end else begin
								do_next = 1'b1;
							end
						end
						EV_RD_ADDR_ACK: begin
							if (len == 8'd1) begin
								res.command       = CMD_NACK;
								nxt.driver_status = ST_BUSY;
							end else if (len == 8'd0) begin
								do_next = 1'b1;
							end else begin
								nxt.driver_status = ST_BUSY;
							end
						end
						EV_RD_DATA_ACK: begin
							if (prog != len) begin
								mem.we             = 1'b1;
								mem.waddr          = pos;
								mem.wdata          = item.rx_data;
								res.rx_store_valid = 1'b1;
								res.rx_store_index = addr_low_byte(pos);
								nxt.byte_progress  = prog_inc;
								if (len != 8'd0 && prog_inc == len - 8'd1) begin
									res.command = CMD_NACK;
								end
								nxt.driver_status = ST_BUSY;
							end else begin
								nxt.driver_status = ST_BUS_ERR;
							end
						end
						EV_RD_DATA_NACK: begin
							if (len != 8'd0 && prog == len - 8'd1) begin
								mem.we             = 1'b1;
								mem.waddr          = pos;
								mem.wdata          = item.rx_data;
								res.rx_store_valid = 1'b1;
								res.rx_store_index = addr_low_byte(pos);
								do_next            = 1'b1;
							end else begin
								nxt.driver_status = ST_BUS_ERR;
							end
						end
						EV_WR_ADDR_NACK, EV_WR_DATA_NACK, EV_RD_ADDR_NACK: begin
							nxt.driver_status = ST_DEV_ERR;
							res.command       = CMD_STOP;
						end
						default: begin
							nxt.driver_status = ST_BUS_ERR;
						end
					endcase
				end
			end
		endcase

		if (do_next) begin
			nxt.current_op    = op_inc;
			nxt.byte_progress = 8'd0;
			if (op_inc == cur.job_op_count) begin
				nxt.driver_status = ST_OK;
				res.command       = CMD_STOP;
			end else begin
				nxt.driver_status = ST_BUSY;
				res.command       = CMD_START;
			end
		end

		res.status = (nxt.driver_status == ST_OK && item.stop_active) ?
			ST_BUSY : nxt.driver_status;
	end

endmodule
`default_nettype wire

// File: src/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer: input register, step logic, result register.
//
// Usage: every input transfer is one item: a descriptor load, a buffer byte load, a job
// start or a controller status event, selected by action. Each accepted item yields
// exactly one result transfer carrying status, the next controller command, the byte to
// send and, on read data, the buffer position the received byte went to.
// Both channels use valid/ready; a transfer happens where both are high.
// An accepted item enters the item register; its result is offered from the result register.
// Throughput: one item per cycle while out_ready keeps up; the item register and the
// result register are separate stages, so a new item is taken while a finished result waits.
// Data bytes to send come from the shared buffer RAM through its registered read
// port, which is read as the result is registered.
// Stall: while out_ready is low the result holds, one further item is taken into the
// item register and then in_ready drops until the result is taken.
// Reset: arst_n clears both stages and the job state (no job, status ok). Descriptor
// and buffer contents are undefined until loaded.
`default_nettype none
module i2c_master_transfer_sequencer
	import i2cms_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [1:0] action,
	input  wire logic [2:0] op_slot,
	input  wire logic [7:0] op_address_byte,
	input  wire logic [7:0] op_length,
	input  wire logic [7:0] op_offset,
	input  wire logic [7:0] byte_index,
	input  wire logic [7:0] byte_value,
	input  wire logic [3:0] op_count,
	input  wire logic [3:0] event_code,
	input  wire logic [7:0] rx_data,
	input  wire logic       stop_active,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [1:0] status,
	output      logic [2:0] command,
	output      logic [7:0] tx_byte,
	output      logic       rx_store_valid,
	output      logic [7:0] rx_store_index
);

	item_t      item_s1;
	logic       valid_s1;
	result_t    res_s2;
	logic       valid_s2;
	seq_state_t state_q;
	seq_state_t state_nxt;
	mem_req_t   mem;
	result_t    res;
	desc_t      desc_rd;
	desc_t      desc_wr;
	logic [7:0] buf_rdata;
	logic       fire;
	logic       desc_we;
	logic [OP_IW+2:0] slot_ext;

	assign fire     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{action, op_slot, op_address_byte, op_length, op_offset,
				byte_index, byte_value, op_count, event_code, rx_data, stop_active};
		end
	end

	assign slot_ext = {{OP_IW{1'b0}}, item_s1.op_slot};
	assign desc_we  = fire && item_s1.action == ACT_LOAD_DESC &&
		32'(item_s1.op_slot) < MAX_OPS;
	assign desc_wr  = '{item_s1.op_address_byte, item_s1.op_length, item_s1.op_offset};

	i2cms_desc_table u_desc (
		.clk   (clk),
		.we    (desc_we),
		.waddr (slot_ext[OP_IW-1:0]),
		.wdata (desc_wr),
		.raddr (state_q.current_op[OP_IW-1:0]),
		.rdata (desc_rd)
	);

	i2cms_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.desc (desc_rd),
		.nxt  (state_nxt),
		.mem  (mem),
		.res  (res)
	);

	i2cms_ram #(
		.WIDTH (8),
		.DEPTH (DATA_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (fire && mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (fire && mem.re),
		.raddr (mem.raddr),
		.rdata (buf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '{'0, '0, 8'd0, ST_OK};
			valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				state_q <= state_nxt;
			end
			if (fire) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign status         = res_s2.status;
	assign command        = res_s2.command;
	assign tx_byte        = res_s2.tx_from_buf ? buf_rdata : res_s2.tx_byte;
	assign rx_store_valid = res_s2.rx_store_valid;
	assign rx_store_index = res_s2.rx_store_index;

`ifndef ASSERT_OFF
	a_op_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.current_op <= state_q.job_op_count)
		else $error("current operation beyond job size");

	a_fire_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("processed item left no result");

	a_store_no_send: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rx_store_valid |-> command != CMD_SEND)
		else $error("store and send in one result");

	a_tx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && command != CMD_SEND |-> tx_byte == 8'd0)
		else $error("tx byte set without send");

	a_ok_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status == ST_OK |-> command == CMD_STOP || command == CMD_NONE)
		else $error("ok status with active command");
`endif

endmodule
`default_nettype wire

// File: bench/i2c_sequencer_checker.sv
// Checker for the I2C master transfer sequencer: predicts every result transfer and compares it.
module i2c_sequencer_checker
	import i2cms_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [1:0] action,
	input  wire logic [2:0] op_slot,
	input  wire logic [7:0] op_address_byte,
	input  wire logic [7:0] op_length,
	input  wire logic [7:0] op_offset,
	input  wire logic [7:0] byte_index,
	input  wire logic [7:0] byte_value,
	input  wire logic [3:0] op_count,
	input  wire logic [3:0] event_code,
	input  wire logic [7:0] rx_data,
	input  wire logic       stop_active,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [1:0] status,
	input  wire logic [2:0] command,
	input  wire logic [7:0] tx_byte,
	input  wire logic       rx_store_valid,
	input  wire logic [7:0] rx_store_index,
	output int              mismatches,
	output int              in_flight,
	output int              results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] command;
		logic [7:0] tx_byte;
		logic       rx_store_valid;
		logic [7:0] rx_store_index;
	} bus_step_t;

	logic [7:0] addr_tab [MAX_OPS];
	logic [7:0] len_tab [MAX_OPS];
	logic [7:0] off_tab [MAX_OPS];
	logic [7:0] data_mem [DATA_DEPTH];
	logic [3:0] op_idx;
	logic [3:0] op_total;
	logic [7:0] progress;
	logic [1:0] drv_status;
	bus_step_t  expected_steps [$];

	function automatic logic [2:0] advance_op();
		op_idx = op_idx + 4'd1;
		progress = '0;
		if (op_idx == op_total) begin
			drv_status = ST_OK;
			return CMD_STOP;
		end
		drv_status = ST_BUSY;
		return CMD_START;
	endfunction

	function automatic bus_step_t sequence_step(input item_t it);
		bus_step_t r;
		logic [7:0] len;
		logic [7:0] pos;
		logic [3:0] total;
		r = '0;
		case (it.action)
			ACT_LOAD_DESC: begin
				addr_tab[it.op_slot] = it.op_address_byte;
				len_tab[it.op_slot] = it.op_length;
				off_tab[it.op_slot] = it.op_offset;
			end
			ACT_LOAD_BYTE: begin
				data_mem[it.byte_index] = it.byte_value;
			end
			ACT_START_JOB: begin
				total = it.op_count;
				if (total == 4'd0)
					total = 4'd1;
				if (total > MAX_OPS)
					total = 4'(MAX_OPS);
				op_total = total;
				op_idx = '0;
				progress = '0;
				drv_status = ST_BUSY;
				r.command = CMD_START;
			end
			ACT_EVENT: begin
				if (op_idx >= op_total) begin
					drv_status = ST_BUS_ERR;
				end else begin
					len = len_tab[op_idx[OP_IW-1:0]];
					pos = off_tab[op_idx[OP_IW-1:0]] + progress;
					case (it.event_code)
						EV_START_DONE, EV_RSTART_DONE: begin
							r.tx_byte = addr_tab[op_idx[OP_IW-1:0]];
							r.command = CMD_SEND;
							drv_status = ST_BUSY;
						end
						EV_WR_ADDR_ACK, EV_WR_DATA_ACK: begin
							if ((it.event_code == EV_WR_ADDR_ACK) ? (len != 8'd0)
									: (progress != len)) begin
								r.tx_byte = data_mem[pos];
								r.command = CMD_SEND;
								progress = progress + 8'd1;
								drv_status = ST_BUSY;
							end else begin
								r.command = advance_op();
							end
						end
						EV_RD_ADDR_ACK: begin
							if (len == 8'd1) begin
								r.command = CMD_NACK;
								drv_status = ST_BUSY;
							end else if (len == 8'd0) begin
								r.command = advance_op();
							end else begin
								drv_status = ST_BUSY;
							end
						end
						EV_RD_DATA_ACK: begin
							if (progress != len) begin
								data_mem[pos] = it.rx_data;
								r.rx_store_valid = 1'b1;
								r.rx_store_index = pos;
								progress = progress + 8'd1;
								if (len != 8'd0 && progress == len - 8'd1)
									r.command = CMD_NACK;
								drv_status = ST_BUSY;
							end else begin
								drv_status = ST_BUS_ERR;
							end
						end
						EV_RD_DATA_NACK: begin
							if (len != 8'd0 && progress == len - 8'd1) begin
								data_mem[pos] = it.rx_data;
								r.rx_store_valid = 1'b1;
								r.rx_store_index = pos;
								progress = progress + 8'd1;
								r.command = advance_op();
							end else begin
								drv_status = ST_BUS_ERR;
							end
						end
						EV_WR_ADDR_NACK, EV_WR_DATA_NACK, EV_RD_ADDR_NACK: begin
							drv_status = ST_DEV_ERR;
							r.command = CMD_STOP;
						end
						default: begin
							drv_status = ST_BUS_ERR;
						end
					endcase
				end
			end
		endcase
		r.status = (drv_status == ST_OK && it.stop_active) ? ST_BUSY : drv_status;
		return r;
	endfunction

	function automatic int field_differs(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got === want)
			return 0;
		$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : compare
		bus_step_t seen;
		bus_step_t want;
		int bad;
		if (!arst_n) begin
			op_idx = '0;
			op_total = '0;
			progress = '0;
			drv_status = ST_OK;
			expected_steps.delete();
			mismatches <= 0;
			in_flight <= 0;
			results_checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen = {status, command, tx_byte, rx_store_valid, rx_store_index};
				if (expected_steps.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %0h", $time, seen);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_steps.pop_front();
					bad = field_differs("status", 8'(want.status), 8'(seen.status))
						+ field_differs("command", 8'(want.command), 8'(seen.command))
						+ field_differs("tx_byte", want.tx_byte, seen.tx_byte)
						+ field_differs("rx_store_valid", 8'(want.rx_store_valid),
							8'(seen.rx_store_valid))
						+ field_differs("rx_store_index", want.rx_store_index,
							seen.rx_store_index);
					if (bad != 0)
						mismatches <= mismatches + 1;
					results_checked <= results_checked + 1;
				end
			end
			if (in_valid && in_ready)
				expected_steps.push_back(sequence_step({action, op_slot, op_address_byte,
					op_length, op_offset, byte_index, byte_value, op_count, event_code,
					rx_data, stop_active}));
			in_flight <= expected_steps.size();
		end
	end

endmodule

// File: bench/i2c_master_transfer_sequencer_test.sv
// Testbench top for the I2C master transfer sequencer: stimulus, handshake pacing and verdict.
module i2c_master_transfer_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;
	import i2cms_pkg::*;

	localparam int ITEM_GOAL = 850;
	localparam int WATCHDOG_LIMIT = 2000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  out_ready = 1'b0;
	item_t drive = '0;

	wire logic       in_ready;
	wire logic       out_valid;
	wire logic [1:0] status;
	wire logic [2:0] command;
	wire logic [7:0] tx_byte;
	wire logic       rx_store_valid;
	wire logic [7:0] rx_store_index;

	int mismatches;
	int in_flight;
	int results_checked;
	int send_idle_pct = 29;
	int recv_idle_pct = 64;
	int items_sent = 0;
	int jobs_run = 0;

	i2c_master_transfer_sequencer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (drive.action),
		.op_slot        (drive.op_slot),
		.op_address_byte(drive.op_address_byte),
		.op_length      (drive.op_length),
		.op_offset      (drive.op_offset),
		.byte_index     (drive.byte_index),
		.byte_value     (drive.byte_value),
		.op_count       (drive.op_count),
		.event_code     (drive.event_code),
		.rx_data        (drive.rx_data),
		.stop_active    (drive.stop_active),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.command        (command),
		.tx_byte        (tx_byte),
		.rx_store_valid (rx_store_valid),
		.rx_store_index (rx_store_index)
	);

	i2c_sequencer_checker seq_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (drive.action),
		.op_slot        (drive.op_slot),
		.op_address_byte(drive.op_address_byte),
		.op_length      (drive.op_length),
		.op_offset      (drive.op_offset),
		.byte_index     (drive.byte_index),
		.byte_value     (drive.byte_value),
		.op_count       (drive.op_count),
		.event_code     (drive.event_code),
		.rx_data        (drive.rx_data),
		.stop_active    (drive.stop_active),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.command        (command),
		.tx_byte        (tx_byte),
		.rx_store_valid (rx_store_valid),
		.rx_store_index (rx_store_index),
		.mismatches     (mismatches),
		.in_flight      (in_flight),
		.results_checked(results_checked)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic item_t random_item();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[$bits(item_t)-1:0];
	endfunction

	function automatic item_t event_item(input logic [3:0] code);
		item_t it;
		it = random_item();
		it.action = ACT_EVENT;
		it.event_code = code;
		return it;
	endfunction

	function automatic item_t desc_item(input logic [2:0] slot, input logic [7:0] addr,
			input logic [7:0] len, input logic [7:0] off);
		item_t it;
		it = random_item();
		it.action = ACT_LOAD_DESC;
		it.op_slot = slot;
		it.op_address_byte = addr;
		it.op_length = len;
		it.op_offset = off;
		return it;
	endfunction

	function automatic item_t byte_item(input logic [7:0] idx, input logic [7:0] val);
		item_t it;
		it = random_item();
		it.action = ACT_LOAD_BYTE;
		it.byte_index = idx;
		it.byte_value = val;
		return it;
	endfunction

	function automatic item_t start_item(input logic [3:0] cnt);
		item_t it;
		it = random_item();
		it.action = ACT_START_JOB;
		it.op_count = cnt;
		return it;
	endfunction

	task automatic push_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		drive <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	task automatic push_job_event(input logic [3:0] code);
		if ($urandom_range(99) < 4)
			push_item(event_item(4'($urandom_range(EV_WR_ADDR_NACK, 15))));
		push_item(event_item(code));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
	endtask

	task automatic run_job();
		int ops;
		int pick;
		logic [7:0] lens [MAX_OPS];
		logic       reads [MAX_OPS];
		logic [7:0] addr;
		logic [3:0] req;
		ops = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_OPS) : $urandom_range(1, 3);
		for (int k = 0; k < ops; k++) begin
			addr = 8'($urandom);
			reads[k] = addr[0];
			pick = $urandom_range(99);
			if (pick == 0)
				lens[k] = 8'($urandom_range(200, 255));
			else if (pick < 8)
				lens[k] = 8'($urandom_range(5, 20));
			else
				lens[k] = 8'($urandom_range(0, 4));
			push_item(desc_item(3'(k), addr, lens[k], 8'($urandom)));
		end
		req = 4'(ops);
		if (ops == 1 && $urandom_range(1) == 1)
			req = 4'd0;
		else if (ops == MAX_OPS && $urandom_range(1) == 1)
			req = 4'($urandom_range(MAX_OPS + 1, 15));
		push_item(start_item(req));
		for (int k = 0; k < ops; k++) begin
			push_job_event((k == 0) ? EV_START_DONE : EV_RSTART_DONE);
			if (!reads[k]) begin
				push_job_event(EV_WR_ADDR_ACK);
				repeat (int'(lens[k]))
					push_job_event(EV_WR_DATA_ACK);
			end else begin
				push_job_event(EV_RD_ADDR_ACK);
				if (lens[k] != 8'd0) begin
					repeat (int'(lens[k]) - 1)
						push_job_event(EV_RD_DATA_ACK);
					push_job_event(EV_RD_DATA_NACK);
				end
			end
		end
		jobs_run++;
	endtask

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		item_t it;
		int goal;
		int base;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		it = event_item(EV_OTHER);
		it.stop_active = 1'b1;
		push_item(it);
		push_item(desc_item(3'd0, 8'h00, 8'd2, 8'hFE));
		push_item(desc_item(3'd1, 8'hA1, 8'd0, 8'h00));
		push_item(desc_item(3'd2, 8'hA3, 8'd1, 8'h00));
		push_item(desc_item(3'd3, 8'hFF, 8'd3, 8'hFF));
		push_item(byte_item(8'hFE, 8'hFF));
		push_item(byte_item(8'hFF, 8'h00));
		push_item(start_item(4'd4));
		push_item(event_item(EV_START_DONE));
		push_item(event_item(EV_WR_ADDR_ACK));
		push_item(event_item(EV_WR_DATA_ACK));
		push_item(event_item(EV_WR_DATA_ACK));
		push_item(event_item(EV_RSTART_DONE));
		push_item(event_item(EV_RD_ADDR_ACK));
		push_item(event_item(EV_RSTART_DONE));
		push_item(event_item(EV_RD_ADDR_ACK));
		push_item(event_item(EV_RD_DATA_NACK));
		push_item(event_item(EV_RSTART_DONE));
		push_item(event_item(EV_RD_ADDR_ACK));
		push_item(event_item(EV_RD_DATA_ACK));
		push_item(event_item(EV_RD_DATA_NACK));
		push_item(event_item(EV_RD_DATA_ACK));
		it = event_item(EV_RD_DATA_NACK);
		it.stop_active = 1'b1;
		push_item(it);
		push_item(event_item(EV_RD_DATA_ACK));
		push_item(start_item(4'd0));
		push_item(desc_item(3'd0, 8'h01, 8'd0, 8'h00));
		push_item(event_item(EV_RD_DATA_ACK));
		push_item(event_item(EV_WR_ADDR_NACK));
		drain();

		for (int i = 0; i < DATA_DEPTH; i++)
			push_item(byte_item(8'(i), 8'($urandom)));
		for (int s = 0; s < MAX_OPS; s++)
			push_item(desc_item(3'(s), 8'($urandom), 8'($urandom), 8'($urandom)));

		base = items_sent;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 64 : 0;
			recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 29 : 0;
			goal = base + (ITEM_GOAL - base) * (phase + 1) / 3;
			while (items_sent < goal) begin
				run_job();
				repeat ($urandom_range(3))
					push_item(random_item());
			end
			drain();
		end

		repeat (4) @(posedge clk);
		$display("Sent %0d items: directed cases, buffer preload, %0d sequenced jobs and noise.",
			items_sent, jobs_run);
		$display("Compared %0d results across three pacing phases.", results_checked);
		if (mismatches == 0 && in_flight == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
